// File: design/dhph_pkg.sv
`default_nettype none

package dhph_pkg;

	// Output speed limit in whole speed units
	localparam int OUT_LIMIT = 1000;
	// Same limit in Q16.16
	localparam longint OUT_CLAMP = longint'(OUT_LIMIT) * 65536;

	// Hold modes, also reported on the result word
	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_HOLD = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef logic [3:0] cfg_index_t;
	localparam cfg_index_t REG_TILT_LIMIT        = 4'd0;
	localparam cfg_index_t REG_STOP_VELOCITY     = 4'd1;
	localparam cfg_index_t REG_STOP_COUNT_LIMIT  = 4'd2;
	localparam cfg_index_t REG_ERROR_RESET_LIMIT = 4'd3;
	localparam cfg_index_t REG_VELOCITY_CLAMP    = 4'd4;
	localparam cfg_index_t REG_PROP_GAIN         = 4'd5;
	localparam cfg_index_t REG_INT_GAIN          = 4'd6;
	localparam cfg_index_t REG_INT_LIMIT         = 4'd7;

	typedef logic [39:0] cfg_data_t;

	// Input word: start or control tick
	typedef struct packed {
		logic               cmd;
		logic signed [15:0] velocity;
		logic signed [15:0] pitch;
		logic        [31:0] now_us;
	} in_word_t;

	localparam logic CMD_START = 1'b0;

	// Result word
	typedef struct packed {
		logic signed [10:0] motor_speed;
		logic               stop_flag;
		mode_t              mode;
	} out_word_t;

	// Microcode
	typedef enum logic [3:0] {
		OP_STOP,
		OP_START,
		OP_WAIT,
		OP_VSUM,
		OP_CLR,
		OP_MINC,
		OP_ERR,
		OP_MHI,
		OP_MLO,
		OP_ACC,
		OP_INT,
		OP_OUT
	} op_t;

	typedef enum logic {
		G_INT,
		G_PROP
	} gsel_t;

	typedef enum logic {
		JC_NONE,
		JC_NO_RESET
	} jcond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		op_t    op;
		gsel_t  gsel;
		jcond_t jcond;
		step_t  target;
		logic   done;
	} ctrl_word_t;

	// Program addresses
	localparam step_t U_STOP   = 4'd0;
	localparam step_t U_START  = 4'd1;
	localparam step_t U_WAIT   = 4'd2;
	localparam step_t U_VSUM   = 4'd3;
	localparam step_t U_CLR    = 4'd4;
	localparam step_t U_MINC   = 4'd5;
	localparam step_t U_ERR    = 4'd6;
	localparam step_t U_IMHI   = 4'd7;
	localparam step_t U_IMLO   = 4'd8;
	localparam step_t U_IACC   = 4'd9;
	localparam step_t U_INT    = 4'd10;
	localparam step_t U_PMHI   = 4'd11;
	localparam step_t U_PMLO   = 4'd12;
	localparam step_t U_PACC   = 4'd13;
	localparam step_t U_OUT    = 4'd14;

	// Control store
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		cw = '{op: OP_STOP, gsel: G_INT, jcond: JC_NONE, target: U_STOP, done: 1'b1};
		case (step)
			U_STOP:  cw = '{OP_STOP,  G_INT,  JC_NONE,     U_STOP, 1'b1};
			U_START: cw = '{OP_START, G_INT,  JC_NONE,     U_STOP, 1'b1};
			U_WAIT:  cw = '{OP_WAIT,  G_INT,  JC_NONE,     U_STOP, 1'b1};
			U_VSUM:  cw = '{OP_VSUM,  G_INT,  JC_NO_RESET, U_MINC, 1'b0};
			U_CLR:   cw = '{OP_CLR,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_MINC:  cw = '{OP_MINC,  G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_ERR:   cw = '{OP_ERR,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_IMHI:  cw = '{OP_MHI,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_IMLO:  cw = '{OP_MLO,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_IACC:  cw = '{OP_ACC,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_INT:   cw = '{OP_INT,   G_INT,  JC_NONE,     U_STOP, 1'b0};
			U_PMHI:  cw = '{OP_MHI,   G_PROP, JC_NONE,     U_STOP, 1'b0};
			U_PMLO:  cw = '{OP_MLO,   G_PROP, JC_NONE,     U_STOP, 1'b0};
			U_PACC:  cw = '{OP_ACC,   G_PROP, JC_NONE,     U_STOP, 1'b0};
			U_OUT:   cw = '{OP_OUT,   G_PROP, JC_NONE,     U_STOP, 1'b1};
			default: cw = '{OP_STOP,  G_INT,  JC_NONE,     U_STOP, 1'b1};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// File: design/drive_halt_position_hold.sv
// Position hold for a drive halt.
// Input channel in_valid / in_stall / in_data carries one word per start or
// control tick; output channel out_valid / out_stall / out_data returns one
// result word for every input word, in order. Configuration registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. A word is
// taken when valid is high and stall is low at a rising edge. Each word
// runs a short microprogram on one shared 24x32 multiplier:
//   start, waiting and plain stop words: one step;
//   holding ticks: 11 steps (12 if the error is cleared), five multiplies.
// The result is registered by the last step. in_stall is high while
// a program runs; the next word is taken while a result still waits.
// If out_stall holds a result, the final step of the next word waits until
// the output register is free, so nothing is lost.
// arst_n clears the mode to plain stop, the controller state to zero, the
// registers to their defaults, and empties the output register.
`default_nettype none

module drive_halt_position_hold (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire dhph_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output dhph_pkg::out_word_t       out_data,
	input  wire logic                 cfg_we,
	input  wire dhph_pkg::cfg_index_t cfg_index,
	input  wire dhph_pkg::cfg_data_t  cfg_data
);
	import dhph_pkg::*;

	// Configuration registers
	logic [14:0] tilt_q;
	logic [14:0] stop_vel_q;
	logic [7:0]  stop_lim_q;
	logic [39:0] err_lim_q;
	logic [14:0] vclamp_q;
	logic [31:0] pgain_q;
	logic [31:0] igain_q;
	logic [30:0] ilim_q;

	// Controller state
	mode_t              hold_mode_q;
	logic [7:0]         still_q;
	logic signed [47:0] perr_q;
	logic signed [31:0] integ_q;
	logic signed [15:0] lastv_q;
	logic [31:0]        lastt_q;

	// Sequencer
	logic       busy_q;
	step_t      step_q;
	step_t      step_d;
	step_t      entry;
	ctrl_word_t cw;
	logic       exec;
	logic       in_acc;

	// Datapath working registers
	in_word_t   in_q;
	logic [15:0] vsum_mag_q;
	logic        vsum_neg_q;
	logic [55:0] mul_q;
	logic [55:0] acc_q;
	logic [47:0] emag_q;
	logic        eneg_q;

	out_word_t  out_q;
	out_word_t  res;
	logic       out_valid_q;

	// Datapath nets
	logic signed [16:0] vel17;
	logic signed [16:0] vcl17;
	logic signed [16:0] vc17;
	logic signed [16:0] vsum17;
	logic [47:0]        perr_mag;
	logic               err_over;
	logic [23:0]        mul_a;
	logic [31:0]        mul_b;
	logic [55:0]        mul_p;
	logic [31:0]        gain;
	logic [47:0]        inc_mag;
	logic signed [49:0] inc_s;
	logic signed [49:0] e_sum;
	logic signed [47:0] e_sat;
	logic signed [57:0] term_adj;
	logic signed [57:0] integ_ext;
	logic signed [57:0] integ_sum;
	logic signed [57:0] ilim58;
	logic signed [57:0] integ_cl;
	logic signed [57:0] t_sum;
	logic signed [57:0] oclamp58;
	logic signed [57:0] t_cl;
	logic [27:0]        t_mag;
	logic [27:0]        t_rnd;
	logic [10:0]        spd_mag;
	logic signed [10:0] speed;
	logic [15:0]        vel_mag;
	logic [15:0]        pitch_mag;
	logic [7:0]         still_d;
	mode_t              start_mode;

	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cw   = ucode(step_q);
	// hold the final step while the output register is still occupied
	assign exec = busy_q && !(cw.done && out_valid_q && out_stall);

	// Pick the program entry from the word type and the current mode
	always_comb begin
		if (in_data.cmd == CMD_START) begin
			entry = U_START;
		end else begin
			case (hold_mode_q)
				MODE_WAIT: entry = U_WAIT;
				MODE_HOLD: entry = U_VSUM;
				default:   entry = U_STOP;
			endcase
		end
	end

	// Advance the step counter, taking conditional jumps
	always_comb begin
		priority if (cw.jcond == JC_NO_RESET && !err_over) begin
			step_d = cw.target;
		end else begin
			step_d = step_q + 4'd1;
		end
	end

	// Clamp velocity and sum with the previous sample
	always_comb begin
		vel17  = 17'(in_q.velocity);
		vcl17  = $signed({2'b00, vclamp_q});
		if (vel17 > vcl17) begin
			vc17 = vcl17;
		end else if (vel17 < -vcl17) begin
			vc17 = -vcl17;
		end else begin
			vc17 = vel17;
		end
		vsum17 = vc17 + 17'(lastv_q);
	end

	// Error magnitude against the clearing limit
	assign perr_mag = perr_q[47] ? 48'(-perr_q) : 48'(perr_q);
	assign err_over = perr_mag >= {8'b0, err_lim_q};

	// Shared multiplier operand selection
	assign gain = (cw.gsel == G_PROP) ? pgain_q : igain_q;
	always_comb begin
		case (cw.op)
			OP_MINC: begin
				mul_a = {8'b0, vsum_mag_q};
				mul_b = in_q.now_us - lastt_q;
			end
			OP_MHI: begin
				mul_a = emag_q[47:24];
				mul_b = gain;
			end
			default: begin
				mul_a = emag_q[23:0];
				mul_b = gain;
			end
		endcase
	end
	assign mul_p = {32'b0, mul_a} * {24'b0, mul_b};

	// Trapezoid increment, truncated toward zero, and saturated error
	always_comb begin
		inc_mag = mul_q[48:1];
		inc_s   = vsum_neg_q ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
		e_sum   = 50'(perr_q) + inc_s;
		if (e_sum[49:47] == 3'b000 || e_sum[49:47] == 3'b111) begin
			e_sat = e_sum[47:0];
		end else if (e_sum[49]) begin
			e_sat = {1'b1, 47'b0};
		end else begin
			e_sat = {1'b0, {47{1'b1}}};
		end
	end

	// Gain term with the sign of the controller (minus the error's sign)
	always_comb begin
		term_adj  = eneg_q ? $signed({2'b00, acc_q}) : -$signed({2'b00, acc_q});
		integ_ext = 58'(integ_q);
		integ_sum = integ_ext + term_adj;
		ilim58    = $signed({27'b0, ilim_q});
		if (integ_sum > ilim58) begin
			integ_cl = ilim58;
		end else if (integ_sum < -ilim58) begin
			integ_cl = -ilim58;
		end else begin
			integ_cl = integ_sum;
		end
		t_sum    = integ_ext + term_adj;
		oclamp58 = 58'(OUT_CLAMP);
		if (t_sum > oclamp58) begin
			t_cl = oclamp58;
		end else if (t_sum < -oclamp58) begin
			t_cl = -oclamp58;
		end else begin
			t_cl = t_sum;
		end
		t_mag   = t_cl[57] ? 28'(-t_cl) : 28'(t_cl);
		t_rnd   = t_mag + 28'd32768;
		spd_mag = t_rnd[26:16];
		speed   = t_cl[57] ? -$signed(spd_mag) : $signed(spd_mag);
	end

	// Stopped-tick counting and start mode choice
	always_comb begin
		vel_mag   = in_q.velocity[15] ? 16'(-in_q.velocity) : 16'(in_q.velocity);
		pitch_mag = in_q.pitch[15] ? 16'(-in_q.pitch) : 16'(in_q.pitch);
		if (vel_mag <= {1'b0, stop_vel_q}) begin
			still_d = (still_q == 8'hFF) ? still_q : still_q + 8'd1;
		end else begin
			still_d = 8'd0;
		end
		start_mode = (pitch_mag > {1'b0, tilt_q}) ? MODE_WAIT : MODE_STOP;
	end

	// Result word of the final step
	always_comb begin
		res = '{motor_speed: 11'sd0, stop_flag: 1'b0, mode: MODE_STOP};
		case (cw.op)
			OP_START: res.mode = start_mode;
			OP_WAIT:  res.mode = MODE_WAIT;
			OP_OUT: begin
				res.motor_speed = speed;
				res.mode        = MODE_HOLD;
			end
			default:  res.stop_flag = 1'b1;
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q     <= 15'd500;
			stop_vel_q <= 15'd13;
			stop_lim_q <= 8'd10;
			err_lim_q  <= 40'd256000000;
			vclamp_q   <= 15'd128;
			pgain_q    <= 32'd0;
			igain_q    <= 32'd0;
			ilim_q     <= 31'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILT_LIMIT:        tilt_q     <= cfg_data[14:0];
				REG_STOP_VELOCITY:     stop_vel_q <= cfg_data[14:0];
				REG_STOP_COUNT_LIMIT:  stop_lim_q <= cfg_data[7:0];
				REG_ERROR_RESET_LIMIT: err_lim_q  <= cfg_data;
				REG_VELOCITY_CLAMP:    vclamp_q   <= cfg_data[14:0];
				REG_PROP_GAIN:         pgain_q    <= cfg_data[31:0];
				REG_INT_GAIN:          igain_q    <= cfg_data[31:0];
				REG_INT_LIMIT:         ilim_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Run the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= U_STOP;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			step_q <= entry;
		end else if (exec) begin
			busy_q <= !cw.done;
			step_q <= step_d;
		end
	end

	// Update controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_mode_q <= MODE_STOP;
			still_q     <= 8'd0;
			perr_q      <= 48'sd0;
			integ_q     <= 32'sd0;
			lastv_q     <= 16'sd0;
			lastt_q     <= 32'd0;
		end else if (exec) begin
			case (cw.op)
				OP_START: begin
					still_q     <= 8'd0;
					perr_q      <= 48'sd0;
					integ_q     <= 32'sd0;
					lastv_q     <= in_q.velocity;
					lastt_q     <= in_q.now_us;
					hold_mode_q <= start_mode;
				end
				OP_WAIT: begin
					still_q <= still_d;
					if (still_d >= stop_lim_q) begin
						hold_mode_q <= MODE_HOLD;
					end
					lastv_q <= in_q.velocity;
					lastt_q <= in_q.now_us;
				end
				OP_STOP:  hold_mode_q <= MODE_STOP;
				OP_CLR: begin
					perr_q  <= 48'sd0;
					integ_q <= 32'sd0;
				end
				OP_ERR:   perr_q  <= e_sat;
				OP_INT:   integ_q <= integ_cl[31:0];
				OP_OUT: begin
					lastv_q <= in_q.velocity;
					lastt_q <= in_q.now_us;
				end
				default: ;
			endcase
		end
	end

	// Capture the input word and step the working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
		if (exec) begin
			case (cw.op)
				OP_VSUM: begin
					vsum_mag_q <= vsum17[16] ? 16'(-vsum17) : 16'(vsum17);
					vsum_neg_q <= vsum17[16];
				end
				OP_MINC, OP_MHI: mul_q <= mul_p;
				OP_MLO: begin
					acc_q <= mul_q;
					mul_q <= mul_p;
				end
				OP_ACC:   acc_q <= acc_q + {24'b0, mul_q[55:24]};
				OP_ERR: begin
					emag_q <= e_sat[47] ? 48'(-e_sat) : 48'(e_sat);
					eneg_q <= e_sat[47];
				end
				default: ;
			endcase
		end
	end

	// Load and drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && cw.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && cw.done) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q)
		else $error("accepted word did not start the program");

	a_result_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result appeared without a running program");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		hold_mode_q != 2'd3)
		else $error("hold mode left the defined codes");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.motor_speed <= 11'(OUT_LIMIT)
			&& out_q.motor_speed >= -11'(OUT_LIMIT)))
		else $error("motor speed beyond limit");

	a_stop_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.stop_flag) |->
			(out_q.mode == MODE_STOP && out_q.motor_speed == 11'sd0))
		else $error("stop word with speed or wrong mode");
`endif

endmodule

`default_nettype wire
